// ===== sv/brd_pkg.sv =====
// Package for the binary rectangular dilation unit: opcodes, register indices, states, mark value.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package brd_pkg;
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_RUN  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [14:0] MARK_VALUE = 15'(255 << 7);
	localparam logic [2:0] REG_FW = 3'd0;
	localparam logic [2:0] REG_FH = 3'd1;
	localparam logic [2:0] REG_KW = 3'd2;
	localparam logic [2:0] REG_KH = 3'd3;
	localparam logic [2:0] REG_PC = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COPY,
		ST_PIX,
		ST_WIN_RD,
		ST_WIN_CHK,
		ST_WRITE,
		ST_DONE,
		ST_READ_WAIT,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== sv/brd_if.sv =====
// Valid/ready channel interfaces for the dilation unit.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface brd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [17:0] pixel_addr;
	logic [14:0] pixel_in;
	modport source (output valid, opcode, pixel_addr, pixel_in, input ready);
	modport sink (input valid, opcode, pixel_addr, pixel_in, output ready);
endinterface

interface brd_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] pixel_out;
	logic        run_done;
	modport source (output valid, pixel_out, run_done, input ready);
	modport sink (input valid, pixel_out, run_done, output ready);
endinterface
`default_nettype wire

// ===== sv/binary_rect_dilation_unit.sv =====
// Binary rectangular dilation unit: frame stores, sequencer, APB registers.
// Depends on brd_pkg, brd_if, brd_frame_ram.
// Load and unused opcodes finish on accept. Read: accept, store read, result.
// Run: accept; per pass, copy the result store into the source store, then for each pixel
// skip it if nonzero, else scan its window until the first mark and write a mark on a hit;
// a closing step ends each pass; then the result. One item at a time, not ready meanwhile.
// Reset clears the control state and restores register defaults; the frame stores hold no reset.
`timescale 1ns / 1ps
`default_nettype none
module binary_rect_dilation_unit #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int MAX_KERNEL = 31
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	brd_in_if.sink           in_ch,
	brd_out_if.source        out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import brd_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int CW = XW + 2;
	localparam int RW = YW + 2;

	state_t state_q, state_d;
	logic [9:0] fw_q, fh_q;
	logic [4:0] kw_q, kh_q;
	logic [7:0] pc_q, pass_q;
	logic [XW:0] w_q;
	logic [YW:0] h_q;
	logic [7:0] kx_q, ky_q;
	logic signed [CW-1:0] x_q, wx_q, wxhi_q;
	logic signed [RW-1:0] y_q, wy_q, wyhi_q;
	logic signed [CW-1:0] wxlo_q;
	logic [AW:0] cidx_q;
	logic copy_rd_q;
	logic [14:0] center_q;
	logic center_first_q;
	logic [14:0] out_pix_q;
	logic out_done_q;
	logic rd_ok_q;

	// register file
	logic [2:0] reg_idx;
	logic wr_en;
	assign reg_idx = paddr[4:2];
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 10'd320;
			fh_q <= 10'd240;
			kw_q <= 5'd3;
			kh_q <= 5'd3;
			pc_q <= 8'd1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FW: fw_q <= pwdata[9:0];
				REG_FH: fh_q <= pwdata[9:0];
				REG_KW: kw_q <= pwdata[4:0];
				REG_KH: kh_q <= pwdata[4:0];
				REG_PC: if (pwdata[7:0] != 8'd0) pc_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		prdata = 32'd0;
		unique case (reg_idx)
			REG_FW: prdata = {22'd0, fw_q};
			REG_FH: prdata = {22'd0, fh_q};
			REG_KW: prdata = {27'd0, kw_q};
			REG_KH: prdata = {27'd0, kh_q};
			REG_PC: prdata = {24'd0, pc_q};
			default: prdata = 32'd0;
		endcase
	end

	// stores
	logic res_we, src_we;
	logic [AW-1:0] res_addr, src_addr;
	logic [14:0] res_wdata, res_rdata, src_rdata;
	brd_frame_ram #(.AW(AW)) u_res (.clk, .we(res_we), .addr(res_addr),
		.wdata(res_wdata), .rdata(res_rdata));
	brd_frame_ram #(.AW(AW)) u_src (.clk, .we(src_we), .addr(src_addr),
		.wdata(res_rdata), .rdata(src_rdata));

	// address units: raster index from (row, col) for the pixel and for the window
	logic [AW-1:0] pix_idx, win_idx;
	assign pix_idx = AW'(y_q[YW-1:0] * w_q + AW'(x_q[XW-1:0]));
	assign win_idx = AW'(wy_q[YW-1:0] * w_q + AW'(wx_q[XW-1:0]));

	logic in_fire, last_pix, win_last;
	logic [AW:0] npix;
	logic [CW-1:0] xmax;
	logic [RW-1:0] ymax;
	assign npix = (AW+1)'(w_q * h_q);
	assign xmax = CW'(w_q) - CW'(1);
	assign ymax = RW'(h_q) - RW'(1);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign last_pix = (x_q == xmax) && (y_q == ymax);
	assign win_last = (wx_q == wxhi_q) && (wy_q == wyhi_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) begin
				unique case (in_ch.opcode)
					OP_RUN:  state_d = ST_COPY;
					OP_READ: state_d = ST_READ_WAIT;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_COPY: if (copy_rd_q && cidx_q == npix) state_d = ST_PIX;
			ST_PIX: state_d = ST_WIN_RD;
			ST_WIN_RD: state_d = ST_WIN_CHK;
			ST_WIN_CHK: begin
				if (center_q != 15'd0) begin
					state_d = last_pix ? ST_DONE : ST_PIX;
				end else if (src_rdata == MARK_VALUE) begin
					state_d = ST_WRITE;
				end else if (win_last) begin
					state_d = last_pix ? ST_DONE : ST_PIX;
				end else begin
					state_d = ST_WIN_RD;
				end
			end
			ST_WRITE: state_d = last_pix ? ST_DONE : ST_PIX;
			ST_DONE: state_d = (pass_q == 8'd1) ? ST_OUT : ST_COPY;
			ST_READ_WAIT: state_d = ST_OUT;
			ST_OUT: if (out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		out_ch.valid = (state_q == ST_OUT);
		out_ch.pixel_out = out_pix_q;
		out_ch.run_done = out_done_q;
		res_we = 1'b0;
		res_addr = cidx_q[AW-1:0];
		res_wdata = MARK_VALUE;
		src_we = 1'b0;
		src_addr = win_idx;
		unique case (state_q)
			ST_IDLE: begin
				res_addr = AW'(in_ch.pixel_addr);
				res_wdata = in_ch.pixel_in;
				res_we = in_fire && in_ch.opcode == OP_LOAD &&
					32'(in_ch.pixel_addr) < DEPTH;
			end
			ST_COPY: begin
				src_addr = AW'(cidx_q - (AW+1)'(1));
				src_we = copy_rd_q;
			end
			ST_PIX: src_addr = pix_idx;
			ST_WRITE: begin
				res_addr = pix_idx;
				res_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic signed [CW-1:0] lo_x, hi_x;
	logic signed [RW-1:0] lo_y, hi_y;
	always_comb begin
		lo_x = x_q - CW'(kx_q);
		if (lo_x[CW-1]) lo_x = '0;
		hi_x = x_q + CW'(kx_q);
		if (hi_x > xmax) hi_x = xmax;
		lo_y = y_q - RW'(ky_q);
		if (lo_y[RW-1]) lo_y = '0;
		hi_y = y_q + RW'(ky_q);
		if (hi_y > ymax) hi_y = ymax;
	end

	logic [4:0] kwc, khc;
	assign kwc = (32'(kw_q) > MAX_KERNEL) ? 5'(MAX_KERNEL) : kw_q;
	assign khc = (32'(kh_q) > MAX_KERNEL) ? 5'(MAX_KERNEL) : kh_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				w_q <= (fw_q == 10'd0) ? (XW+1)'(1) :
					(32'(fw_q) > MAX_WIDTH) ? (XW+1)'(MAX_WIDTH) : (XW+1)'(fw_q);
				h_q <= (fh_q == 10'd0) ? (YW+1)'(1) :
					(32'(fh_q) > MAX_HEIGHT) ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(fh_q);
				kx_q <= 8'(kwc >> 1);
				ky_q <= 8'(khc >> 1);
				pass_q <= pc_q;
				cidx_q <= '0;
				copy_rd_q <= 1'b0;
				x_q <= '0;
				y_q <= '0;
				rd_ok_q <= 32'(in_ch.pixel_addr) < DEPTH;
				out_done_q <= (in_ch.opcode == OP_RUN);
				out_pix_q <= '0;
			end
			ST_COPY: begin
				copy_rd_q <= 1'b1;
				cidx_q <= cidx_q + (AW+1)'(1);
				if (copy_rd_q && cidx_q == npix) begin
					x_q <= '0;
					y_q <= '0;
				end
			end
			ST_PIX: begin
				wx_q <= lo_x;
				wy_q <= lo_y;
				wxlo_q <= lo_x;
				wxhi_q <= hi_x;
				wyhi_q <= hi_y;
			end
			ST_WIN_RD: ;
			ST_WIN_CHK: begin
				if (wx_q == wxhi_q) begin
					wx_q <= wxlo_q;
					wy_q <= wy_q + RW'(1);
				end else begin
					wx_q <= wx_q + CW'(1);
				end
			end
			ST_DONE: begin
				pass_q <= pass_q - 8'd1;
				cidx_q <= '0;
				copy_rd_q <= 1'b0;
			end
			ST_READ_WAIT: out_pix_q <= rd_ok_q ? res_rdata : 15'd0;
			default: ;
		endcase
		// first window read cycle sees the center pixel's source value
		if (state_q == ST_WIN_RD && center_first_q) begin
			center_q <= src_rdata;
		end
		if ((state_q == ST_WIN_CHK && state_d == ST_PIX) || (state_q == ST_WRITE)) begin
			if (x_q == xmax) begin
				x_q <= '0;
				y_q <= y_q + RW'(1);
			end else begin
				x_q <= x_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		center_first_q <= (state_q == ST_PIX);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.pixel_out) &&
		$stable(out_ch.run_done));
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid));
	a_state_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(state_q));
	a_copy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY |-> cidx_q <= npix);
endmodule
`default_nettype wire

// ===== sv/brd_frame_ram.sv =====
// Single-port frame store with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module brd_frame_ram #(
	parameter int AW = 18
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [14:0]   wdata,
	output logic [14:0]        rdata
);
	logic [14:0] mem [2**AW];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire
